@@ sv/wetc_pkg.sv @@
// shared types and constants for the tumbling window extreme and threshold count block
// no dependencies

package wetc_pkg;

   localparam int POS_W      = 32;
   localparam int SCORE_W    = 32;
   localparam int COUNT_W    = 24;
   localparam int CHROM_W    = 8;
   localparam int DIVIDEND_W = POS_W + 1;
   localparam int DIVISOR_W  = COUNT_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] DEFAULT_WINDOW = COUNT_W'(100000);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

   // register index, taken from the word address
   localparam logic REG_CUTOFF = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   localparam logic KIND_SITE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic RES_WINDOW = 1'b0;
   localparam logic RES_RUN    = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/window_extreme_threshold_count.sv @@
// a site inside the open window passes idle, decide and add, and the block is then ready again
// a site past the window, or a new chromosome after an open one, also waits on the divider,
// a shared divider used once for the tail run and once for the skipped gap
// each result waits for the output register to drain; the last result of an item marks last
// reset is synchronous: cutoff 0, window size 100000, nothing started; no clearing pass
// depends on wetc_pkg and wetc_div

module window_extreme_threshold_count (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [wetc_pkg::CHROM_W-1:0]         req_chrom_id,
   input  logic [wetc_pkg::POS_W-1:0]           req_chrom_len,
   input  logic [wetc_pkg::POS_W-1:0]           req_position,
   input  logic signed [wetc_pkg::SCORE_W-1:0]  req_score,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_type,
   output logic [wetc_pkg::CHROM_W-1:0]         rsp_out_chrom,
   output logic [wetc_pkg::POS_W-1:0]           rsp_window_start,
   output logic [wetc_pkg::POS_W-1:0]           rsp_window_end,
   output logic signed [wetc_pkg::SCORE_W-1:0]  rsp_extreme_value,
   output logic [wetc_pkg::POS_W-1:0]           rsp_extreme_position,
   output logic [wetc_pkg::COUNT_W-1:0]         rsp_beyond_count,
   output logic [wetc_pkg::COUNT_W-1:0]         rsp_site_count,
   output logic [wetc_pkg::COUNT_W-1:0]         rsp_empty_windows,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WIN,
      ST_TAIL_GO,
      ST_TAIL_WAIT,
      ST_TAIL_OUT,
      ST_RUN_GO,
      ST_RUN_WAIT,
      ST_RUN_OUT,
      ST_ADD
   } state_type;

   localparam int PW = wetc_pkg::POS_W;
   localparam int CW = wetc_pkg::COUNT_W;

   // configuration
   logic signed [wetc_pkg::SCORE_W-1:0] cutoff_ff;
   logic [CW-1:0]                       window_size_ff;

   // window state
   state_type                           state_ff;
   logic                                started_ff;
   logic [wetc_pkg::CHROM_W-1:0]        cur_chrom_ff;
   logic [PW-1:0]                       cur_len_ff;
   logic [PW-1:0]                       win_lo_ff;
   logic [PW-1:0]                       win_hi_ff;
   logic signed [wetc_pkg::SCORE_W-1:0] best_score_ff;
   logic [PW-1:0]                       best_pos_ff;
   logic [CW-1:0]                       hits_ff;
   logic [CW-1:0]                       sites_ff;

   // item held for the sequence
   logic                                item_kind_ff;
   logic [wetc_pkg::CHROM_W-1:0]        item_chrom_ff;
   logic [PW-1:0]                       item_len_ff;
   logic [PW-1:0]                       item_pos_ff;
   logic signed [wetc_pkg::SCORE_W-1:0] item_score_ff;
   logic                                same_ff;
   logic                                tail_need_ff;
   logic                                run_need_ff;
   logic [PW-1:0]                       run_start_ff;
   logic [PW-1:0]                       run_p_ff;
   logic [PW-1:0]                       run_lo_ff;
   logic [CW-1:0]                       run_k_ff;

   // output register
   logic                                rsp_valid_ff;
   logic                                rsp_type_ff;
   logic [wetc_pkg::CHROM_W-1:0]        rsp_chrom_ff;
   logic [PW-1:0]                       rsp_start_ff;
   logic [PW-1:0]                       rsp_end_ff;
   logic signed [wetc_pkg::SCORE_W-1:0] rsp_ext_ff;
   logic [PW-1:0]                       rsp_epos_ff;
   logic [CW-1:0]                       rsp_beyond_ff;
   logic [CW-1:0]                       rsp_sites_ff;
   logic [CW-1:0]                       rsp_empty_ff;
   logic                                rsp_last_ff;

   logic                                accept;
   logic                                cfg_write;
   logic                                out_free;
   logic                                rsp_load;
   logic [CW-1:0]                       ws_eff;
   logic [PW-1:0]                       pos_eff;
   logic [PW-1:0]                       gap_same;
   logic [PW-1:0]                       gap_new;
   logic [wetc_pkg::DIVIDEND_W-1:0]     tail_num;
   logic                                div_start;
   logic [wetc_pkg::DIVIDEND_W-1:0]     div_dividend;
   wetc_pkg::div_status_type            div_status;
   logic [wetc_pkg::DIVIDEND_W-1:0]     div_quo;
   logic [wetc_pkg::DIVISOR_W-1:0]      div_rem;
   logic [CW-1:0]                       quo_sat;
   logic [PW-1:0]                       open_lo;
   logic [PW:0]                         open_sum;
   logic [PW-1:0]                       open_hi;
   logic                                win_last;
   logic                                min_mode;
   logic                                first_site;
   logic                                better;
   logic                                beyond;
   logic [CW-1:0]                       hits_base;
   logic [CW-1:0]                       hits_in;
   logic [CW-1:0]                       sites_in;

   // an end is capped at the chromosome length when that length is known and reached
   function automatic logic [PW-1:0] cap_end(input logic [PW-1:0] len,
                                             input logic [PW-1:0] start,
                                             input logic [PW-1:0] stop);
      if (len != '0 && len >= start && stop > len) begin
         return len;
      end
      return stop;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == wetc_pkg::REG_WINDOW) ? {8'd0, window_size_ff}
                                                        : cutoff_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == ST_WIN || state_ff == ST_TAIL_OUT ||
                                   state_ff == ST_RUN_OUT);
   assign ws_eff    = (window_size_ff == '0) ? CW'(1) : window_size_ff;
   assign pos_eff   = (item_pos_ff == '0) ? PW'(1) : item_pos_ff;
   assign gap_same  = item_pos_ff - PW'(1) - win_hi_ff;
   assign gap_new   = pos_eff - PW'(1);
   assign tail_num  = {1'b0, cur_len_ff} - {1'b0, win_hi_ff} + {9'd0, ws_eff}
                      - wetc_pkg::DIVIDEND_W'(1);

   assign div_start    = (state_ff == ST_TAIL_GO) || (state_ff == ST_RUN_GO);
   assign div_dividend = (state_ff == ST_TAIL_GO) ? tail_num
                       : {1'b0, (same_ff ? gap_same : gap_new)};

   wetc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (ws_eff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign quo_sat  = (div_quo[wetc_pkg::DIVIDEND_W-1:CW] != '0) ? wetc_pkg::COUNT_MAX
                                                              : div_quo[CW-1:0];
   // first position of the window holding the site is the site minus the gap remainder
   assign open_lo  = run_p_ff - {8'd0, div_rem};
   assign open_sum = {1'b0, open_lo} + {9'd0, ws_eff} - (PW+1)'(1);
   assign open_hi  = open_sum[PW] ? '1 : open_sum[PW-1:0];

   always_comb begin
      if (item_kind_ff == wetc_pkg::KIND_END) begin
         win_last = !tail_need_ff;
      end else if (same_ff) begin
         win_last = !run_need_ff;
      end else begin
         win_last = !tail_need_ff && !run_need_ff;
      end
   end

   // site update, judged under the cutoff in force now
   assign min_mode   = cutoff_ff[wetc_pkg::SCORE_W-1];
   assign first_site = sites_ff == '0;
   assign better     = min_mode ? (item_score_ff < best_score_ff)
                                : (item_score_ff > best_score_ff);
   assign beyond     = min_mode ? (item_score_ff < cutoff_ff) : (item_score_ff > cutoff_ff);
   assign hits_base  = first_site ? '0 : hits_ff;
   assign hits_in    = (beyond && hits_base != wetc_pkg::COUNT_MAX) ? hits_base + 1'b1
                                                                    : hits_base;
   assign sites_in   = (sites_ff != wetc_pkg::COUNT_MAX) ? sites_ff + 1'b1 : sites_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff      <= '0;
         window_size_ff <= wetc_pkg::DEFAULT_WINDOW;
      end else if (cfg_write) begin
         unique case (paddr[2])
            wetc_pkg::REG_CUTOFF: cutoff_ff      <= pwdata;
            wetc_pkg::REG_WINDOW: window_size_ff <= pwdata[CW-1:0];
            default:              cutoff_ff      <= cutoff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         cur_chrom_ff  <= '0;
         cur_len_ff    <= '0;
         win_lo_ff     <= PW'(1);
         win_hi_ff     <= {8'd0, wetc_pkg::DEFAULT_WINDOW};
         best_score_ff <= '0;
         best_pos_ff   <= '0;
         hits_ff       <= '0;
         sites_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  item_kind_ff  <= req_kind;
                  item_chrom_ff <= req_chrom_id;
                  item_len_ff   <= req_chrom_len;
                  item_pos_ff   <= req_position;
                  item_score_ff <= req_score;
                  state_ff      <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               same_ff      <= started_ff && item_chrom_ff == cur_chrom_ff;
               tail_need_ff <= cur_len_ff != '0 && win_hi_ff < cur_len_ff;
               if (item_kind_ff == wetc_pkg::KIND_END) begin
                  state_ff <= started_ff ? ST_WIN : ST_IDLE;
               end else if (started_ff && item_chrom_ff == cur_chrom_ff) begin
                  run_need_ff <= gap_same >= {8'd0, ws_eff};
                  state_ff    <= (item_pos_ff > win_hi_ff) ? ST_WIN : ST_ADD;
               end else begin
                  run_need_ff <= gap_new >= {8'd0, ws_eff};
                  state_ff    <= started_ff ? ST_WIN : ST_RUN_GO;
               end
            end
            ST_WIN: begin
               if (out_free) begin
                  rsp_type_ff   <= wetc_pkg::RES_WINDOW;
                  rsp_chrom_ff  <= cur_chrom_ff;
                  rsp_start_ff  <= win_lo_ff;
                  rsp_end_ff    <= cap_end(cur_len_ff, win_lo_ff, win_hi_ff);
                  rsp_ext_ff    <= best_score_ff;
                  rsp_epos_ff   <= best_pos_ff;
                  rsp_beyond_ff <= hits_ff;
                  rsp_sites_ff  <= sites_ff;
                  rsp_empty_ff  <= '0;
                  rsp_last_ff   <= win_last;
                  if (item_kind_ff == wetc_pkg::KIND_END) begin
                     if (tail_need_ff) begin
                        state_ff <= ST_TAIL_GO;
                     end else begin
                        started_ff <= 1'b0;
                        state_ff   <= ST_IDLE;
                     end
                  end else if (same_ff) begin
                     state_ff <= ST_RUN_GO;
                  end else begin
                     state_ff <= tail_need_ff ? ST_TAIL_GO : ST_RUN_GO;
                  end
               end
            end
            ST_TAIL_GO: begin
               state_ff <= ST_TAIL_WAIT;
            end
            ST_TAIL_WAIT: begin
               if (div_status.done) begin
                  state_ff <= ST_TAIL_OUT;
               end
            end
            ST_TAIL_OUT: begin
               if (out_free) begin
                  rsp_type_ff   <= wetc_pkg::RES_RUN;
                  rsp_chrom_ff  <= cur_chrom_ff;
                  rsp_start_ff  <= win_hi_ff + 1'b1;
                  rsp_end_ff    <= cur_len_ff;
                  rsp_ext_ff    <= '0;
                  rsp_epos_ff   <= '0;
                  rsp_beyond_ff <= '0;
                  rsp_sites_ff  <= '0;
                  rsp_empty_ff  <= quo_sat;
                  if (item_kind_ff == wetc_pkg::KIND_END) begin
                     rsp_last_ff <= 1'b1;
                     started_ff  <= 1'b0;
                     state_ff    <= ST_IDLE;
                  end else begin
                     rsp_last_ff <= !run_need_ff;
                     state_ff    <= ST_RUN_GO;
                  end
               end
            end
            ST_RUN_GO: begin
               // divider takes its dividend this cycle, from the item and the old window
               if (same_ff) begin
                  run_start_ff <= win_hi_ff + 1'b1;
                  run_p_ff     <= item_pos_ff;
               end else begin
                  run_start_ff <= PW'(1);
                  run_p_ff     <= pos_eff;
                  started_ff   <= 1'b1;
                  cur_chrom_ff <= item_chrom_ff;
                  cur_len_ff   <= item_len_ff;
               end
               state_ff <= ST_RUN_WAIT;
            end
            ST_RUN_WAIT: begin
               if (div_status.done) begin
                  win_lo_ff <= open_lo;
                  win_hi_ff <= open_hi;
                  hits_ff   <= '0;
                  sites_ff  <= '0;
                  run_lo_ff <= open_lo;
                  run_k_ff  <= quo_sat;
                  state_ff  <= (div_quo != '0) ? ST_RUN_OUT : ST_ADD;
               end
            end
            ST_RUN_OUT: begin
               if (out_free) begin
                  rsp_type_ff   <= wetc_pkg::RES_RUN;
                  rsp_chrom_ff  <= cur_chrom_ff;
                  rsp_start_ff  <= run_start_ff;
                  rsp_end_ff    <= cap_end(cur_len_ff, run_start_ff, run_lo_ff - 1'b1);
                  rsp_ext_ff    <= '0;
                  rsp_epos_ff   <= '0;
                  rsp_beyond_ff <= '0;
                  rsp_sites_ff  <= '0;
                  rsp_empty_ff  <= run_k_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_ADD;
               end
            end
            ST_ADD: begin
               if (first_site || better) begin
                  best_score_ff <= item_score_ff;
                  best_pos_ff   <= item_pos_ff;
               end
               hits_ff  <= hits_in;
               sites_ff <= sites_in;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_type      = rsp_type_ff;
   assign rsp_out_chrom        = rsp_chrom_ff;
   assign rsp_window_start     = rsp_start_ff;
   assign rsp_window_end       = rsp_end_ff;
   assign rsp_extreme_value    = rsp_ext_ff;
   assign rsp_extreme_position = rsp_epos_ff;
   assign rsp_beyond_count     = rsp_beyond_ff;
   assign rsp_site_count       = rsp_sites_ff;
   assign rsp_empty_windows    = rsp_empty_ff;
   assign rsp_last             = rsp_last_ff;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      win_hi_ff >= win_lo_ff)
      else $error("window end below window start");

   a_open_has_site: assert property (@(posedge clock) disable iff (reset)
      (started_ff && state_ff == ST_IDLE) |-> sites_ff != '0)
      else $error("open window holds no site");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_type_ff == wetc_pkg::RES_RUN) |-> rsp_empty_ff != '0)
      else $error("run result with no empty window");

endmodule

@@ sv/wetc_div.sv @@
// restoring divider, one quotient bit per cycle, for gap and tail window counts
// depends on wetc_pkg

module wetc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wetc_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [wetc_pkg::DIVISOR_W-1:0]      divisor,
   output wetc_pkg::div_status_type            status,
   output logic [wetc_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [wetc_pkg::DIVISOR_W-1:0]      remainder
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [wetc_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [wetc_pkg::DIVIDEND_W-1:0]    quo_ff;
   logic [wetc_pkg::DIVISOR_W-1:0]     rem_ff;
   logic [wetc_pkg::DIVISOR_W-1:0]     dvs_ff;

   logic [wetc_pkg::DIVISOR_W:0]       trial;
   logic [wetc_pkg::DIVISOR_W:0]       diff;
   logic                               ge;
   logic [wetc_pkg::DIVISOR_W-1:0]     rem_in;

   assign trial  = {rem_ff, quo_ff[wetc_pkg::DIVIDEND_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign diff   = trial - {1'b0, dvs_ff};
   // a failed trial is below the divisor, so it fits the remainder width
   assign rem_in = ge ? diff[wetc_pkg::DIVISOR_W-1:0] : trial[wetc_pkg::DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= wetc_pkg::DIV_CNT_W'(wetc_pkg::DIV_STEPS - 1);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[wetc_pkg::DIVIDEND_W-2:0], ge};
            rem_ff <= rem_in;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule
